// File: src/kbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbw_pkg
// Widths, coefficients and stage types shared by the window evaluator.
// ----------------------------------------------------------------------------
package kbw_pkg;

  localparam int POS_W    = 24;
  localparam int WID_W    = 23;
  localparam int T_W      = 25;
  localparam int REM_W    = 23;
  localparam int Q_W      = 32;
  localparam int ARG_W    = 33;
  localparam int PROD_W   = 65;
  localparam int N_COEF   = 13;
  localparam int N_HORNER = 12;
  localparam int N_DIV    = 32;

  localparam logic [WID_W-1:0] WIDTH_RESET = 23'd65536;
  localparam logic [Q_W-1:0]   ONE_Q31     = 32'h8000_0000;
  localparam logic [Q_W-1:0]   HALF_Q32    = 32'h8000_0000;

  // series terms in q1.31, c0 first
  localparam logic [Q_W-1:0] COEF [N_COEF] = '{
    32'd24652972,
    32'd243315078,
    32'd600355891,
    32'd658363905,
    32'd406111956,
    32'd160326574,
    32'd43954441,
    32'd8853325,
    32'd1365294,
    32'd166357,
    32'd16419,
    32'd1339,
    32'd92
  };

  typedef struct packed {
    logic             in_win;
    logic [REM_W-1:0] t;
  } prep_t;

  typedef struct packed {
    logic             in_win;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } div_t;

  typedef struct packed {
    logic             in_win;
    logic [ARG_W-1:0] arg;
  } sq_t;

  typedef struct packed {
    logic             in_win;
    logic [ARG_W-1:0] arg;
    logic [Q_W-1:0]   acc;
  } hor_t;

endpackage

// File: src/kbw_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbw_prep
// Forms 2|x| and decides whether the position lies inside the window.
// ----------------------------------------------------------------------------
module kbw_prep import kbw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [WID_W-1:0]        window_width,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output prep_t                   out_data
);

  logic [POS_W-1:0] mag;
  logic [T_W-1:0]   t;
  logic             in_win;
  logic             en;

  assign mag    = position[POS_W-1] ? (~position + POS_W'(1)) : position;
  assign t      = {mag, 1'b0};
  assign in_win = (window_width != '0) && (t < T_W'(window_width));
  assign en     = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.in_win <= in_win;
      out_data.t      <= t[REM_W-1:0];
    end
  end

endmodule

// File: src/kbw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbw_div
// Restoring divider, one quotient bit per stage: r = floor(t * 2^32 / W).
// ----------------------------------------------------------------------------
module kbw_div import kbw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [WID_W-1:0] window_width,
  input  logic             in_valid,
  output logic             in_ready,
  input  prep_t            in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output div_t             out_data
);

  div_t              stg      [N_DIV];
  div_t              stg_next [N_DIV];
  div_t              src      [N_DIV];
  logic [N_DIV-1:0]  vld;
  logic [N_DIV:0]    en;

  assign en[N_DIV] = out_ready;
  assign in_ready  = en[0];
  assign out_valid = vld[N_DIV-1];
  assign out_data  = stg[N_DIV-1];

  always_comb begin
    logic [REM_W:0] sh;
    logic           ge;
    src[0].in_win = in_data.in_win;
    src[0].rem    = in_data.t;
    src[0].q      = '0;
    for (int i = 1; i < N_DIV; i++) begin
      src[i] = stg[i-1];
    end
    for (int i = 0; i < N_DIV; i++) begin
      sh = {src[i].rem, 1'b0};
      ge = sh >= (REM_W+1)'(window_width);
      stg_next[i].in_win = src[i].in_win;
      stg_next[i].rem    = ge ? REM_W'(sh - (REM_W+1)'(window_width)) : sh[REM_W-1:0];
      stg_next[i].q      = {src[i].q[Q_W-2:0], ge};
    end
  end

  for (genvar i = 0; i < N_DIV; i++) begin : g_stage
    assign en[i] = ~vld[i] | en[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en[i]) begin
        vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        stg[i] <= stg_next[i];
      end
    end
  end

endmodule

// File: src/kbw_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbw_square
// Squares the ratio with rounding and forms arg = 1 - r^2 in q1.32.
// ----------------------------------------------------------------------------
module kbw_square import kbw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sq_t  out_data
);

  logic [2*Q_W-1:0] prod;
  logic [2*Q_W-1:0] rnd;
  logic [ARG_W-1:0] arg;
  logic             en;

  assign prod = (2*Q_W)'(in_data.q) * (2*Q_W)'(in_data.q);
  assign rnd  = prod + (2*Q_W)'(HALF_Q32);
  assign arg  = {1'b1, {Q_W{1'b0}}} - ARG_W'(rnd[2*Q_W-1:Q_W]);
  assign en   = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.in_win <= in_data.in_win;
      out_data.arg    <= arg;
    end
  end

endmodule

// File: src/kbw_horner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbw_horner
// Degree-12 polynomial in arg by Horner's rule, one multiply-add per stage.
// ----------------------------------------------------------------------------
module kbw_horner import kbw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sq_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output hor_t out_data
);

  hor_t                stg      [N_HORNER];
  hor_t                stg_next [N_HORNER];
  hor_t                src      [N_HORNER];
  logic [N_HORNER-1:0] vld;
  logic [N_HORNER:0]   en;

  assign en[N_HORNER] = out_ready;
  assign in_ready     = en[0];
  assign out_valid    = vld[N_HORNER-1];
  assign out_data     = stg[N_HORNER-1];

  always_comb begin
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rnd;
    logic [Q_W+1:0]    sum;
    src[0].in_win = in_data.in_win;
    src[0].arg    = in_data.arg;
    src[0].acc    = COEF[N_COEF-1];
    for (int j = 1; j < N_HORNER; j++) begin
      src[j] = stg[j-1];
    end
    for (int j = 0; j < N_HORNER; j++) begin
      prod = PROD_W'(src[j].acc) * PROD_W'(src[j].arg);
      rnd  = prod + PROD_W'(HALF_Q32);
      sum  = (Q_W+2)'(rnd[PROD_W-1:Q_W]) + (Q_W+2)'(COEF[N_COEF-2-j]);
      stg_next[j].in_win = src[j].in_win;
      stg_next[j].arg    = src[j].arg;
      stg_next[j].acc    = sum[Q_W-1:0];
    end
  end

  for (genvar j = 0; j < N_HORNER; j++) begin : g_stage
    assign en[j] = ~vld[j] | en[j+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en[j]) begin
        vld[j] <= (j == 0) ? in_valid : vld[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        stg[j] <= stg_next[j];
      end
    end
  end

endmodule

// File: src/kaiser_bessel_window_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaiser_bessel_window_eval
// Kaiser-Bessel window (alpha = 2 pi) weight for a signed q15.8 position.
// ----------------------------------------------------------------------------
// The block accepts one position per clock and returns its weight through a
// chain of registered stages: the range check, the bit-per-stage divider that
// forms 2|x|/W, the square, 12 Horner multiply-add stages and the saturating
// output register. Every stage holds its item under backpressure and empty
// stages close up, so throughput stays at one item per cycle while the
// consumer keeps up. The width register is written through the cfg channel,
// which is always ready; write it only while no item is in flight. Positions
// with 2|x| >= W (and any position when W is zero) give a weight of zero with
// inside_window low.
// ----------------------------------------------------------------------------
module kaiser_bessel_window_eval import kbw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [WID_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [Q_W-1:0]          window_value,
  output logic                    inside_window
);

  logic [WID_W-1:0] window_width;

  logic  prep_valid, prep_ready;
  prep_t prep_data;
  logic  div_valid, div_ready;
  div_t  div_data;
  logic  sq_valid, sq_ready;
  sq_t   sq_data;
  logic  hor_valid, hor_ready;
  hor_t  hor_data;

  logic           en;
  logic [Q_W-1:0] sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_width <= cfg_data;
    end
  end

  kbw_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .window_width (window_width),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .position     (position),
    .out_valid    (prep_valid),
    .out_ready    (prep_ready),
    .out_data     (prep_data)
  );

  kbw_div u_div (
    .clk          (clk),
    .rst          (rst),
    .window_width (window_width),
    .in_valid     (prep_valid),
    .in_ready     (prep_ready),
    .in_data      (prep_data),
    .out_valid    (div_valid),
    .out_ready    (div_ready),
    .out_data     (div_data)
  );

  kbw_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  kbw_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (hor_valid),
    .out_ready (hor_ready),
    .out_data  (hor_data)
  );

  // saturate at 1.0, zero outside the window
  assign sat       = (hor_data.acc > ONE_Q31) ? ONE_Q31 : hor_data.acc;
  assign en        = ~out_valid | out_ready;
  assign hor_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= hor_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      window_value  <= hor_data.in_win ? sat : '0;
      inside_window <= hor_data.in_win;
    end
  end

endmodule

// File: tb/sv/kbw_weight_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbw_weight_checker
// Watches the width, position and weight channels of the window evaluator.
// Each accepted position is turned into an expected weight and flag with the
// block's fixed-point Horner evaluation at the width currently held. Each
// accepted output item is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module kbw_weight_checker import kbw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [WID_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [POS_W-1:0] position,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [Q_W-1:0]          window_value,
  input  logic                    inside_window,
  output int                      mismatches,
  output int                      pending
);

  typedef struct packed {
    logic [Q_W-1:0] value;
    logic           in_win;
  } weight_t;

  logic [WID_W-1:0] width_q;
  weight_t          expected_weights [$];

  function automatic bit [63:0] series_q31(input int k);
    case (k)
      0:       return 64'd24652972;
      1:       return 64'd243315078;
      2:       return 64'd600355891;
      3:       return 64'd658363905;
      4:       return 64'd406111956;
      5:       return 64'd160326574;
      6:       return 64'd43954441;
      7:       return 64'd8853325;
      8:       return 64'd1365294;
      9:       return 64'd166357;
      10:      return 64'd16419;
      11:      return 64'd1339;
      default: return 64'd92;
    endcase
  endfunction

  function automatic weight_t kb_weight(input logic signed [POS_W-1:0] pos,
                                        input logic [WID_W-1:0] w);
    bit [63:0] mag;
    bit [63:0] t;
    bit [63:0] r;
    bit [63:0] sq;
    bit [63:0] arg;
    bit [63:0] acc;
    weight_t   res;
    if (pos[POS_W-1]) begin
      mag = (64'd1 << POS_W) - {40'd0, pos};
    end else begin
      mag = {40'd0, pos};
    end
    t = mag << 1;
    res.value = '0;
    res.in_win = 1'b0;
    if (w == '0 || t >= {41'd0, w}) return res;
    r = (t << 32) / {41'd0, w};
    sq = (r * r + 64'h8000_0000) >> 32;
    arg = (64'd1 << 32) - sq;
    acc = series_q31(12);
    for (int k = 11; k >= 0; k--) begin
      acc = ((acc * arg + 64'h8000_0000) >> 32) + series_q31(k);
    end
    if (acc > 64'h8000_0000) acc = 64'h8000_0000;
    res.value = acc[Q_W-1:0];
    res.in_win = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    weight_t want;
    if (rst) begin
      width_q <= WIDTH_RESET;
      expected_weights.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) width_q <= cfg_data;
      if (in_valid && in_ready) expected_weights.push_back(kb_weight(position, width_q));
      if (out_valid && out_ready) begin
        if (expected_weights.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual value %h inside %b",
                   $time, window_value, inside_window);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_weights.pop_front();
          if (window_value !== want.value || inside_window !== want.in_win) begin
            if (window_value !== want.value)
              $display("%0t: window_value expected %h actual %h",
                       $time, want.value, window_value);
            if (inside_window !== want.in_win)
              $display("%0t: inside_window expected %b actual %b",
                       $time, want.in_win, inside_window);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_weights.size();
    end
  end

endmodule

// File: tb/sv/kaiser_bessel_window_eval_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaiser_bessel_window_eval_test
// Stimulus and verdict for the Kaiser-Bessel window evaluator.
// A directed run covers zero, extreme and edge-of-window positions at the
// reset width, zero width, unit width and the largest width. Random phases
// then sweep widths from 1 to the maximum under varied sender and receiver
// pacing, including one long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module kaiser_bessel_window_eval_test;
  import kbw_pkg::*;

  typedef enum int {
    PACE_FREE,
    PACE_SENDER_IDLE,
    PACE_SINK_STALL,
    PACE_BOTH
  } pace_e;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [WID_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [POS_W-1:0] position;
  logic                    out_valid;
  logic                    out_ready;
  logic [Q_W-1:0]          window_value;
  logic                    inside_window;
  int                      mismatches;
  int                      pending;
  int                      idle_pct = 0;
  int                      stall_pct = 0;
  bit                      hold_req = 1'b0;

  kaiser_bessel_window_eval uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window_value (window_value),
    .inside_window(inside_window)
  );

  kbw_weight_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window_value (window_value),
    .inside_window(inside_window),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always #10 clk = ~clk;

  // all tasks start and end at a falling edge
  task automatic send_position(input logic signed [POS_W-1:0] x);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_width(input logic [WID_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FREE: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        idle_pct = 60;
        stall_pct = 0;
      end
      PACE_SINK_STALL: begin
        idle_pct = 0;
        stall_pct = 60;
      end
      default: begin
        idle_pct = 32;
        stall_pct = 32;
      end
    endcase
  endtask

  // mostly inside the window, some at its edge, some anywhere
  function automatic logic signed [POS_W-1:0] pick_position(input logic [WID_W-1:0] w);
    int unsigned       half;
    int unsigned       mag;
    int unsigned       sel;
    logic [POS_W-1:0]  x;
    half = (w == '0) ? 0 : (w - 1) / 2;
    sel = $urandom_range(9);
    if (sel >= 8) return POS_W'($urandom);
    if (sel >= 6) mag = half + $urandom_range(2, 0);
    else mag = $urandom_range(half, 0);
    x = mag[POS_W-1:0];
    if ($urandom_range(1)) x = -x;
    return x;
  endfunction

  function automatic logic [WID_W-1:0] phase_width(input int p);
    case (p)
      0:       return 23'd65536;
      1:       return 23'd1;
      2:       return 23'd8388607;
      3:       return WID_W'($urandom_range(255, 1));
      4:       return WID_W'($urandom_range(8388607, 1));
      5:       return WID_W'($urandom_range(65535, 256));
      6:       return WID_W'($urandom_range(8388607, 65536));
      default: return WID_W'($urandom_range(8388607, 1));
    endcase
  endfunction

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    logic [WID_W-1:0] w;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    position = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_pace(PACE_FREE);
    send_position(24'sd0);
    send_position(24'sd1);
    send_position(-24'sd1);
    send_position(24'sd32767);
    send_position(-24'sd32767);
    send_position(24'sd32768);
    send_position(-24'sd32768);
    send_position(24'sd32769);
    send_position(24'sd8388607);
    send_position(-24'sd8388608);
    send_position(24'sh555555);
    send_position(24'shAAAAAA);

    // zero width: everything is outside
    write_width(23'd0);
    send_position(24'sd0);
    send_position(24'sd1);
    send_position(-24'sd8388608);

    write_width(23'd1);
    send_position(24'sd0);
    send_position(24'sd1);
    send_position(-24'sd1);

    write_width(23'd8388607);
    send_position(24'sd4194303);
    send_position(24'sd4194304);
    send_position(-24'sd4194303);
    send_position(-24'sd4194304);
    send_position(-24'sd8388608);
    send_position(24'sd0);

    for (int p = 0; p < 8; p++) begin
      w = phase_width(p);
      write_width(w);
      set_pace(pace_e'(p % 4));
      if (p == 0) hold_req = 1'b1;
      repeat (175) send_position(pick_position(w));
    end

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
src/kbw_pkg.sv
src/kbw_prep.sv
src/kbw_div.sv
src/kbw_square.sv
src/kbw_horner.sv
src/kaiser_bessel_window_eval.sv
tb/sv/kbw_weight_checker.sv
tb/sv/kaiser_bessel_window_eval_test.sv
